FILE: src/cartridge_bank_mapper_with_irq_timer_macros.svh
// Assertion macros shared by the mapper RTL.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_TIMER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_TIMER_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define CBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cbm_pkg.sv
// Types, register codes and constants of the cartridge bank mapper.
package cbm_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_PRG   = 2'd2,
    CMD_CHR   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic irq;
    logic mirror;
  } status_t;

  localparam logic [15:0] REG_PRG0      = 16'h8000;
  localparam logic [15:0] REG_PRG1      = 16'hA000;
  localparam logic [15:0] REG_PRG2      = 16'hC000;
  localparam logic [15:0] REG_MIRROR    = 16'h9000;
  localparam logic [15:0] REG_IRQ_CTRL  = 16'h9003;
  localparam logic [15:0] REG_IRQ_LOAD  = 16'h9004;
  localparam logic [15:0] REG_LATCH_HI  = 16'h9005;
  localparam logic [15:0] REG_LATCH_LO  = 16'h9006;
  localparam logic [15:0] REG_CHR_FIRST = 16'hB000;
  localparam logic [15:0] REG_CHR_LAST  = 16'hB007;

  localparam int MIRROR_BIT = 6;
  localparam int ENABLE_BIT = 7;

  localparam logic [1:0]       PRG_FIXED_SLOT  = 2'd3;
  localparam logic [7:0]       FIXED_LAST_BANK = 8'hFF;
  localparam logic [2:0][7:0]  PRG_RESET       = {8'hFE, 8'h01, 8'h00};
  localparam logic [7:0]       MASK_RESET      = 8'hFF;

  localparam logic CFG_PRG_MASK = 1'b0;
  localparam logic CFG_CHR_MASK = 1'b1;

endpackage

FILE: src/cbm_if.sv
// Valid/ready channel interfaces for mapper requests and results.
interface cbm_in_if;
  logic            valid;
  logic            ready;
  logic [1:0]      cmd;
  logic [15:0]     addr;
  logic [7:0]      data;

  modport source (output valid, output cmd, output addr, output data, input ready);
  modport sink (input valid, input cmd, input addr, input data, output ready);
endinterface

interface cbm_out_if;
  logic            valid;
  logic            ready;
  logic            irq_pending;
  logic            mapped;
  logic [20:0]     rom_address;
  logic            mirror_horizontal;

  modport source (output valid, output irq_pending, output mapped, output rom_address,
                  output mirror_horizontal, input ready);
  modport sink (input valid, input irq_pending, input mapped, input rom_address,
                input mirror_horizontal, output ready);
endinterface

FILE: src/cbm_state.sv
// Bank, mirroring and IRQ counter registers updated by CPU writes and ticks.
`include "cartridge_bank_mapper_with_irq_timer_macros.svh"

module cbm_state (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  cbm_pkg::req_t       req,
  output cbm_pkg::status_t    status_nxt,
  output logic [2:0][7:0]     prg_bank,
  output logic [7:0][7:0]     chr_bank
);

  logic [2:0][7:0] prg_bank_r, prg_bank_nxt;
  logic [7:0][7:0] chr_bank_r, chr_bank_nxt;
  logic            mirror_r, mirror_nxt;
  logic            count_en_r, count_en_nxt;
  logic            irq_r, irq_nxt;
  logic [15:0]     cnt_r, cnt_nxt;
  logic [15:0]     latch_r, latch_nxt;
  logic [15:0]     cnt_dec;

  assign cnt_dec = cnt_r - 16'd1;

  always_comb begin
    prg_bank_nxt = prg_bank_r;
    chr_bank_nxt = chr_bank_r;
    mirror_nxt   = mirror_r;
    count_en_nxt = count_en_r;
    irq_nxt      = irq_r;
    cnt_nxt      = cnt_r;
    latch_nxt    = latch_r;
    if (fire && req.cmd == cbm_pkg::CMD_WRITE) begin
      case (req.addr)
        cbm_pkg::REG_PRG0: prg_bank_nxt[0] = req.data;
        cbm_pkg::REG_PRG1: prg_bank_nxt[1] = req.data;
        cbm_pkg::REG_PRG2: prg_bank_nxt[2] = req.data;
        cbm_pkg::REG_MIRROR: mirror_nxt = req.data[cbm_pkg::MIRROR_BIT];
        cbm_pkg::REG_IRQ_CTRL: begin
          count_en_nxt = req.data[cbm_pkg::ENABLE_BIT];
          irq_nxt      = 1'b0;
        end
        cbm_pkg::REG_IRQ_LOAD: begin
          cnt_nxt = latch_r;
          irq_nxt = 1'b0;
        end
        cbm_pkg::REG_LATCH_HI: latch_nxt = {req.data, latch_r[7:0]};
        cbm_pkg::REG_LATCH_LO: latch_nxt = {latch_r[15:8], req.data};
        default: begin
          if (req.addr inside {[cbm_pkg::REG_CHR_FIRST:cbm_pkg::REG_CHR_LAST]}) begin
            chr_bank_nxt[req.addr[2:0]] = req.data;
          end
        end
      endcase
    end else if (fire && req.cmd == cbm_pkg::CMD_TICK && count_en_r) begin
      cnt_nxt = cnt_dec;
      if (cnt_dec == 16'd0) begin
        irq_nxt      = 1'b1;
        count_en_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_r <= cbm_pkg::PRG_RESET;
      for (int i = 0; i < 8; i++) begin
        chr_bank_r[i] <= 8'(i);
      end
      mirror_r   <= 1'b0;
      count_en_r <= 1'b0;
      irq_r      <= 1'b0;
      cnt_r      <= 16'd0;
      latch_r    <= 16'd0;
    end else begin
      prg_bank_r <= prg_bank_nxt;
      chr_bank_r <= chr_bank_nxt;
      mirror_r   <= mirror_nxt;
      count_en_r <= count_en_nxt;
      irq_r      <= irq_nxt;
      cnt_r      <= cnt_nxt;
      latch_r    <= latch_nxt;
    end
  end

  assign status_nxt.irq    = irq_nxt;
  assign status_nxt.mirror = mirror_nxt;
  assign prg_bank          = prg_bank_r;
  assign chr_bank          = chr_bank_r;

  `CBM_ASSERT_NEXT(a_expire, clk, rst_n,
    fire && req.cmd == cbm_pkg::CMD_TICK && count_en_r && cnt_r == 16'd1,
    irq_r && !count_en_r, "counter expiry did not raise the IRQ")
  `CBM_ASSERT_NOW(a_irq_source, clk, rst_n, $rose(irq_r),
    $past(fire) && $past(req.cmd) == cbm_pkg::CMD_TICK, "IRQ rose without a tick")
  `CBM_ASSERT_NOW(a_irq_stops_count, clk, rst_n, irq_r, !count_en_r,
    "counter still enabled while the IRQ is pending")

endmodule

FILE: src/cbm_xlate.sv
// PRG and CHR address translation through the bank registers and masks.
module cbm_xlate (
  input  cbm_pkg::req_t    req,
  input  logic [2:0][7:0]  prg_bank,
  input  logic [7:0][7:0]  chr_bank,
  input  logic [7:0]       prg_mask,
  input  logic [7:0]       chr_mask,
  output logic             mapped,
  output logic [20:0]      rom_address
);

  logic [7:0] prg_sel;
  logic [7:0] chr_sel;

  always_comb begin
    case (req.addr[14:13])
      2'd0: prg_sel = prg_bank[0];
      2'd1: prg_sel = prg_bank[1];
      2'd2: prg_sel = prg_bank[2];
      cbm_pkg::PRG_FIXED_SLOT: prg_sel = cbm_pkg::FIXED_LAST_BANK;
      default: prg_sel = cbm_pkg::FIXED_LAST_BANK;
    endcase
    chr_sel = chr_bank[req.addr[12:10]];
  end

  always_comb begin
    mapped      = 1'b0;
    rom_address = 21'd0;
    case (req.cmd)
      cbm_pkg::CMD_PRG: begin
        if (req.addr[15]) begin
          mapped      = 1'b1;
          rom_address = {prg_sel & prg_mask, req.addr[12:0]};
        end
      end
      cbm_pkg::CMD_CHR: begin
        if (!req.addr[13]) begin
          mapped      = 1'b1;
          rom_address = {3'b000, chr_sel & chr_mask, req.addr[9:0]};
        end
      end
      default: begin
        mapped      = 1'b0;
        rom_address = 21'd0;
      end
    endcase
  end

endmodule

FILE: src/cartridge_bank_mapper_with_irq_timer.sv
// Top level of the cartridge bank mapper with CPU-cycle IRQ counter.
//
//   Channel   Direction  Handshake         Contents
//   in_bus    sink       valid/ready       cmd, addr, data
//   out_bus   source     valid/ready       irq_pending, mapped, rom_address, mirror_horizontal
//   cfg_*     slave      APB, pready high  prg_bank_mask at 0x0, chr_bank_mask at 0x4
//
// One request is accepted every cycle unless back pressure on out_bus stalls the pipeline.
// A request sits in the input register, then the decode, counter and translation logic
// updates the state and loads the result register together.
// Back pressure on out_bus stalls both registers; ready follows out_bus.ready combinationally.
// Synchronous active-low reset restores the bank registers, masks and IRQ counter.
`include "cartridge_bank_mapper_with_irq_timer_macros.svh"

module cartridge_bank_mapper_with_irq_timer (
  input  logic              clk,
  input  logic              rst_n,
  cbm_in_if.sink            in_bus,
  cbm_out_if.source         out_bus,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic               in_valid_r;
  cbm_pkg::req_t      in_req_r;
  logic               out_valid_r;
  logic               out_irq_r;
  logic               out_mapped_r;
  logic [20:0]        out_rom_r;
  logic               out_mirror_r;
  logic [7:0]         prg_mask_r;
  logic [7:0]         chr_mask_r;
  logic               adv;
  logic               fire;
  logic               cfg_wr;
  cbm_pkg::status_t   status_nxt;
  logic [2:0][7:0]    prg_bank;
  logic [7:0][7:0]    chr_bank;
  logic               mapped;
  logic [20:0]        rom_address;

  assign adv          = !out_valid_r || out_bus.ready;
  assign fire         = in_valid_r && adv;
  assign in_bus.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_req_r.cmd  <= cbm_pkg::cmd_t'(in_bus.cmd);
      in_req_r.addr <= in_bus.addr;
      in_req_r.data <= in_bus.data;
    end
  end

  cbm_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .req        (in_req_r),
    .status_nxt (status_nxt),
    .prg_bank   (prg_bank),
    .chr_bank   (chr_bank)
  );

  cbm_xlate u_xlate (
    .req         (in_req_r),
    .prg_bank    (prg_bank),
    .chr_bank    (chr_bank),
    .prg_mask    (prg_mask_r),
    .chr_mask    (chr_mask_r),
    .mapped      (mapped),
    .rom_address (rom_address)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_irq_r    <= status_nxt.irq;
      out_mirror_r <= status_nxt.mirror;
      out_mapped_r <= mapped;
      out_rom_r    <= rom_address;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.irq_pending       = out_irq_r;
  assign out_bus.mapped            = out_mapped_r;
  assign out_bus.rom_address       = out_rom_r;
  assign out_bus.mirror_horizontal = out_mirror_r;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_mask_r <= cbm_pkg::MASK_RESET;
      chr_mask_r <= cbm_pkg::MASK_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        cbm_pkg::CFG_PRG_MASK: prg_mask_r <= cfg_pwdata[7:0];
        cbm_pkg::CFG_CHR_MASK: chr_mask_r <= cfg_pwdata[7:0];
        default: prg_mask_r <= prg_mask_r;
      endcase
    end
  end

  assign cfg_prdata = {24'd0, (cfg_paddr[2] == cbm_pkg::CFG_CHR_MASK) ? chr_mask_r : prg_mask_r};

  `CBM_ASSERT_NOW(a_unmapped_zero, clk, rst_n, out_valid_r && !out_mapped_r,
    out_rom_r == 21'd0, "unmapped result carries a nonzero ROM address")
  `CBM_ASSERT_NEXT(a_stall_holds, clk, rst_n, in_valid_r && !adv,
    in_valid_r && $stable(in_req_r), "stalled request was lost from the input register")

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the cartridge bank mapper: random-gap driver, stalling monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        irq_pending;
    logic        mapped;
    logic [20:0] rom_address;
    logic        mirror_horizontal;
  } map_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cbm_in_if  in_ch ();
  cbm_out_if out_ch ();

  cartridge_bank_mapper_with_irq_timer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_ch),
    .out_bus     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  cbm_pkg::req_t request_backlog[$];
  map_result_t   expected_translations[$];
  int unsigned   items_queued;
  int unsigned   results_seen;
  int unsigned   errors;
  int unsigned   irq_raises;
  int unsigned   mapped_lookups;
  int unsigned   mask_writes;
  int unsigned   send_gap;
  int unsigned   recv_stall;
  bit            calm;

  logic [7:0]  prg_mask_m;
  logic [7:0]  chr_mask_m;
  logic [7:0]  prg_bank_m[3];
  logic [7:0]  chr_bank_m[8];
  logic        mirror_m;
  logic        count_en_m;
  logic        irq_m;
  logic [15:0] counter_m;
  logic [15:0] latch_m;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic translate_request(input cbm_pkg::req_t r, output map_result_t res);
    logic [7:0]  bank;
    logic [13:0] ppu_addr;
    res = '0;
    case (r.cmd)
      cbm_pkg::CMD_WRITE: begin
        case (r.addr)
          cbm_pkg::REG_PRG0:     prg_bank_m[0] = r.data;
          cbm_pkg::REG_PRG1:     prg_bank_m[1] = r.data;
          cbm_pkg::REG_PRG2:     prg_bank_m[2] = r.data;
          cbm_pkg::REG_MIRROR:   mirror_m = r.data[cbm_pkg::MIRROR_BIT];
          cbm_pkg::REG_IRQ_CTRL: begin
            count_en_m = r.data[cbm_pkg::ENABLE_BIT];
            irq_m = 1'b0;
          end
          cbm_pkg::REG_IRQ_LOAD: begin
            counter_m = latch_m;
            irq_m = 1'b0;
          end
          cbm_pkg::REG_LATCH_HI: latch_m[15:8] = r.data;
          cbm_pkg::REG_LATCH_LO: latch_m[7:0] = r.data;
          default: begin
            if (r.addr inside {[cbm_pkg::REG_CHR_FIRST:cbm_pkg::REG_CHR_LAST]})
              chr_bank_m[r.addr[2:0]] = r.data;
          end
        endcase
      end
      cbm_pkg::CMD_TICK: begin
        if (count_en_m) begin
          counter_m = counter_m - 16'd1;
          if (counter_m == 16'd0) begin
            irq_m = 1'b1;
            count_en_m = 1'b0;
            irq_raises++;
          end
        end
      end
      cbm_pkg::CMD_PRG: begin
        if (r.addr[15]) begin
          bank = (r.addr[14:13] == cbm_pkg::PRG_FIXED_SLOT) ? cbm_pkg::FIXED_LAST_BANK
                                                             : prg_bank_m[r.addr[14:13]];
          res.mapped = 1'b1;
          res.rom_address = {bank & prg_mask_m, r.addr[12:0]};
        end
      end
      cbm_pkg::CMD_CHR: begin
        ppu_addr = r.addr[13:0];
        if (!ppu_addr[13]) begin
          bank = chr_bank_m[ppu_addr[12:10]] & chr_mask_m;
          res.mapped = 1'b1;
          res.rom_address = {3'd0, bank, ppu_addr[9:0]};
        end
      end
      default: begin
      end
    endcase
    res.irq_pending = irq_m;
    res.mirror_horizontal = mirror_m;
    if (res.mapped) mapped_lookups++;
  endtask

  function automatic void check_field(string name, logic [20:0] want, logic [20:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : sender
    cbm_pkg::req_t taken;
    cbm_pkg::req_t nxt;
    map_result_t   res;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
      prg_mask_m = cbm_pkg::MASK_RESET;
      chr_mask_m = cbm_pkg::MASK_RESET;
      for (int i = 0; i < 3; i++) prg_bank_m[i] = cbm_pkg::PRG_RESET[i];
      for (int i = 0; i < 8; i++) chr_bank_m[i] = i[7:0];
      mirror_m = 1'b0;
      count_en_m = 1'b0;
      irq_m = 1'b0;
      counter_m = 16'd0;
      latch_m = 16'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.cmd = cbm_pkg::cmd_t'(in_ch.cmd);
        taken.addr = in_ch.addr;
        taken.data = in_ch.data;
        translate_request(taken, res);
        expected_translations.push_back(res);
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap == 0 && !calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 11);
        if (send_gap > 0) begin
          in_ch.valid <= 1'b0;
          send_gap--;
        end else if (request_backlog.size() > 0) begin
          nxt = request_backlog.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= nxt.cmd;
          in_ch.addr <= nxt.addr;
          in_ch.data <= nxt.data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    map_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_translations.size() == 0) begin
          $error("result arrived with no request outstanding");
          errors++;
        end else begin
          want = expected_translations.pop_front();
          results_seen++;
          check_field("irq_pending", 21'(want.irq_pending), 21'(out_ch.irq_pending));
          check_field("mapped", 21'(want.mapped), 21'(out_ch.mapped));
          check_field("rom_address", want.rom_address, out_ch.rom_address);
          check_field("mirror_horizontal", 21'(want.mirror_horizontal),
                      21'(out_ch.mirror_horizontal));
        end
      end
      if (recv_stall == 0 && !calm && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 11);
      if (recv_stall > 0) begin
        out_ch.ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_request(input cbm_pkg::cmd_t c, input logic [15:0] a,
                               input logic [7:0] d);
    cbm_pkg::req_t r;
    r.cmd = c;
    r.addr = a;
    r.data = d;
    request_backlog.push_back(r);
    items_queued++;
  endtask

  function automatic cbm_pkg::req_t random_request();
    cbm_pkg::req_t r;
    int unsigned   pick;
    pick = $urandom_range(0, 99);
    r.addr = 16'($urandom);
    r.data = 8'($urandom);
    if (pick < 14) begin
      r.cmd = cbm_pkg::CMD_WRITE;
      case ($urandom_range(0, 8))
        0: r.addr = cbm_pkg::REG_PRG0;
        1: r.addr = cbm_pkg::REG_PRG1;
        2: r.addr = cbm_pkg::REG_PRG2;
        3: r.addr = cbm_pkg::REG_MIRROR;
        4: r.addr = cbm_pkg::REG_IRQ_CTRL;
        5: r.addr = cbm_pkg::REG_IRQ_LOAD;
        6: r.addr = cbm_pkg::REG_LATCH_HI;
        7: r.addr = cbm_pkg::REG_LATCH_LO;
        default: r.addr = cbm_pkg::REG_CHR_FIRST | 16'($urandom_range(0, 7));
      endcase
    end else if (pick < 22) begin
      r.cmd = cbm_pkg::CMD_WRITE;
      if ($urandom_range(0, 1) == 1)
        r.addr = {4'($urandom_range(8, 15)), 8'h00, 4'($urandom_range(0, 15))};
    end else if (pick < 50) begin
      r.cmd = cbm_pkg::CMD_TICK;
    end else if (pick < 75) begin
      r.cmd = cbm_pkg::CMD_PRG;
      if ($urandom_range(0, 4) != 0) r.addr[15] = 1'b1;
    end else begin
      r.cmd = cbm_pkg::CMD_CHR;
    end
    return r;
  endfunction

  // Load a count, usually a short one, start the counter and clock it, mixed with other traffic.
  task automatic queue_timer_program();
    logic [7:0]    hi;
    logic [7:0]    lo;
    int unsigned   ticks;
    cbm_pkg::req_t r;
    hi = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
    lo = (hi == 8'h00) ? 8'($urandom_range(1, 24)) : 8'($urandom);
    ticks = $urandom_range(0, 32);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_LATCH_HI, hi);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_LATCH_LO, lo);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_IRQ_LOAD, 8'($urandom));
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_IRQ_CTRL,
                  8'($urandom) | 8'(1 << cbm_pkg::ENABLE_BIT));
    repeat (ticks) begin
      if ($urandom_range(0, 9) < 7) begin
        queue_request(cbm_pkg::CMD_TICK, 16'($urandom), 8'($urandom));
      end else begin
        r = random_request();
        queue_request(r.cmd, r.addr, r.data);
      end
    end
  endtask

  task automatic queue_random_phase(input int unsigned n);
    int unsigned   stop;
    cbm_pkg::req_t r;
    stop = items_queued + n;
    while (items_queued < stop) begin
      if ($urandom_range(0, 5) == 0) begin
        queue_timer_program();
      end else begin
        r = random_request();
        queue_request(r.cmd, r.addr, r.data);
      end
    end
  endtask

  task automatic wait_idle();
    while (results_seen != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mask(input logic idx, input logic [7:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == cbm_pkg::CFG_PRG_MASK) prg_mask_m = value;
    else chr_mask_m = value;
    mask_writes++;
    @(negedge clk);
    check_field("cfg_prdata", 21'(value), 21'(cfg_prdata));
  endtask

  initial begin
    rst_n = 1'b0;
    calm = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = cbm_pkg::CMD_WRITE;
    in_ch.addr = 16'd0;
    in_ch.data = 8'd0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = 3'd0;
    cfg_pwdata = 32'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset banks, window edges, PPU address folding, unmapped areas, register writes and IRQ counter.
    queue_request(cbm_pkg::CMD_TICK, 16'hFFFF, 8'hFF);
    queue_request(cbm_pkg::CMD_PRG, 16'h8000, 8'h00);
    queue_request(cbm_pkg::CMD_PRG, 16'hFFFF, 8'hFF);
    queue_request(cbm_pkg::CMD_PRG, 16'h7FFF, 8'h00);
    queue_request(cbm_pkg::CMD_CHR, 16'h0000, 8'h00);
    queue_request(cbm_pkg::CMD_CHR, 16'h1FFF, 8'hFF);
    queue_request(cbm_pkg::CMD_CHR, 16'h2000, 8'h00);
    queue_request(cbm_pkg::CMD_CHR, 16'hDC05, 8'h00);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_PRG0, 8'hFF);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_PRG1, 8'h00);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_PRG2, 8'hA5);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_CHR_LAST, 8'hFF);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_CHR_FIRST, 8'h5A);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_MIRROR, 8'(1 << cbm_pkg::MIRROR_BIT));
    queue_request(cbm_pkg::CMD_WRITE, 16'h8001, 8'hFF);
    queue_request(cbm_pkg::CMD_WRITE, 16'h9001, 8'hFF);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_LATCH_HI, 8'h00);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_LATCH_LO, 8'h03);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_IRQ_LOAD, 8'h00);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_IRQ_CTRL, 8'(1 << cbm_pkg::ENABLE_BIT));
    repeat (4) queue_request(cbm_pkg::CMD_TICK, 16'h0000, 8'h00);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_IRQ_LOAD, 8'hFF);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_IRQ_CTRL, 8'hFF);
    repeat (3) queue_request(cbm_pkg::CMD_TICK, 16'h5555, 8'hAA);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_IRQ_CTRL, 8'h7F);
    queue_request(cbm_pkg::CMD_PRG, 16'hC000, 8'h00);
    queue_request(cbm_pkg::CMD_CHR, 16'h1C00, 8'h00);
    queue_request(cbm_pkg::CMD_WRITE, cbm_pkg::REG_MIRROR, ~8'(1 << cbm_pkg::MIRROR_BIT));
    wait_idle();

    set_mask(cbm_pkg::CFG_PRG_MASK, 8'h00);
    set_mask(cbm_pkg::CFG_CHR_MASK, 8'h00);
    queue_random_phase(80);
    wait_idle();

    set_mask(cbm_pkg::CFG_PRG_MASK, 8'h1F);
    set_mask(cbm_pkg::CFG_CHR_MASK, 8'h7F);
    queue_random_phase(80);
    wait_idle();

    set_mask(cbm_pkg::CFG_PRG_MASK, 8'($urandom));
    set_mask(cbm_pkg::CFG_CHR_MASK, 8'($urandom));
    queue_random_phase(100);
    wait_idle();

    set_mask(cbm_pkg::CFG_PRG_MASK, 8'($urandom));
    set_mask(cbm_pkg::CFG_CHR_MASK, 8'($urandom));
    queue_random_phase(100);
    wait_idle();
    calm = 1'b1;
    queue_random_phase(60);
    wait_idle();
    repeat (10) @(posedge clk);

    if (expected_translations.size() != 0) begin
      $error("%0d expected results never arrived", expected_translations.size());
      errors++;
    end
    $display("Covered %0d requests: %0d mapped lookups and %0d IRQ raises,",
             items_queued, mapped_lookups, irq_raises);
    $display("with %0d mask register writes between traffic phases.", mask_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
